### hw/rtl/sepv_pkg.sv
// Shared constants for the sine-error PID velocity controller.
`default_nettype none
package sepv_pkg;

	localparam int unsigned REG_INDEX_W = 3;
	localparam int unsigned DATA_W      = 16;

	localparam logic [REG_INDEX_W-1:0] REG_KP     = 3'd0;
	localparam logic [REG_INDEX_W-1:0] REG_KI     = 3'd1;
	localparam logic [REG_INDEX_W-1:0] REG_KD     = 3'd2;
	localparam logic [REG_INDEX_W-1:0] REG_LIMIT  = 3'd3;
	localparam logic [REG_INDEX_W-1:0] REG_TARGET = 3'd4;

	localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;
	localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
	localparam logic [19:0] US_PER_SECOND  = 20'd1000000;
	localparam logic signed [48:0] INTEGRAL_MAX = 49'sh0_7FFF_FFFF_FFFF;
	localparam logic [14:0] LIMIT_RESET = 15'd32767;

endpackage
`default_nettype wire

### hw/rtl/sine_error_pid_velocity.sv
// PID velocity controller on the sine of the roll angle, bit-serial datapath.
`default_nettype none
// One request goes in at a time; the input stalls from acceptance until the result is
// registered. A request passes through a shift-add multiplier that
// retires one multiplier bit per cycle and runs six products (phase, P, error*dt, I, and two
// for D), a restoring divider runs two 64-step divisions (integral by 1e6, derivative by
// dt), plus a registered sine table read and a few add steps. A new request is taken while
// the previous result still waits on a stalled output. No clearing pass follows reset.
module sine_error_pid_velocity #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     item_valid,
	output logic                    item_stall,
	input  wire signed [14:0]       roll_angle,
	input  wire        [19:0]       elapsed_us,
	output logic                    result_valid,
	input  wire                     result_stall,
	output logic signed [15:0]      wheel_velocity,
	output logic                    limited,
	input  wire                     write_enable,
	input  wire [sepv_pkg::REG_INDEX_W-1:0] reg_index,
	input  wire [sepv_pkg::DATA_W-1:0]      write_data
);

	localparam int QUARTER = 1 << SINE_TABLE_BITS;
	localparam int AW = SINE_TABLE_BITS + 1;
	localparam logic [63:0] PHASE_RND = 64'd1 << (41 - SINE_TABLE_BITS);

	typedef logic [14:0] rom_t [0:QUARTER];

	function automatic rom_t build_rom();
		rom_t r;
		logic [63:0] x, x2, t, s, e;
		for (int i = 0; i <= QUARTER; i++) begin
			x = (64'(i) * sepv_pkg::HALF_PI_Q30 + (64'd1 << (SINE_TABLE_BITS - 1)))
				>> SINE_TABLE_BITS;
			x2 = (x * x) >> 30;
			t = 64'd1 << 30;
			t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd110;
			t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
			t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
			t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
			t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
			s = (x * t) >> 30;
			e = (s + (64'd1 << 15)) >> 16;
			if (e > 64'd16384)
				e = 64'd16384;
			r[i] = e[14:0];
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PHASE = 4'd1;
	localparam logic [3:0] ST_ROM   = 4'd2;
	localparam logic [3:0] ST_SINE  = 4'd3;
	localparam logic [3:0] ST_MP    = 4'd4;
	localparam logic [3:0] ST_ME    = 4'd5;
	localparam logic [3:0] ST_MI    = 4'd6;
	localparam logic [3:0] ST_DI    = 4'd7;
	localparam logic [3:0] ST_ADDI  = 4'd8;
	localparam logic [3:0] ST_MD1   = 4'd9;
	localparam logic [3:0] ST_MD2   = 4'd10;
	localparam logic [3:0] ST_DD    = 4'd11;
	localparam logic [3:0] ST_ADDD  = 4'd12;
	localparam logic [3:0] ST_FIN   = 4'd13;

	logic [3:0]  state_q;
	logic [5:0]  cnt_q;
	logic        result_valid_q;
	logic [15:0] kp_q, ki_q, kd_q;
	logic [14:0] limit_q;
	logic signed [15:0] target_q;
	logic signed [47:0] integral_q;
	logic signed [16:0] prev_q;

	logic        roll_neg_q;
	logic [19:0] dt_q;
	logic [AW-1:0] addr_q;
	logic        sin_neg_q;
	logic [14:0] rom_q;
	logic signed [16:0] err_q;
	logic signed [17:0] de_q;
	logic        ineg_q;
	logic [63:0] mul_a_q;
	logic [19:0] mul_b_q;
	logic [63:0] prod_q;
	logic [63:0] div_n_q;
	logic [19:0] div_d_q;
	logic [19:0] div_r_q;
	logic signed [55:0] sum_q;
	logic signed [15:0] vel_q;
	logic        lim_q;

	logic accept, mul_done, fire;
	logic [14:0] roll_mag;
	logic [63:0] phase_w;
	logic [SINE_TABLE_BITS-1:0] idx_w;
	logic [1:0] quad_w;
	logic signed [15:0] sin_w;
	logic signed [16:0] err_w;
	logic [16:0] err_w_mag;
	logic [16:0] err_mag;
	logic [17:0] de_mag;
	logic signed [48:0] acc_w, acc_sat;
	logic [47:0] acc_mag;
	logic [20:0] div_t;
	logic div_ge;
	logic [19:0] div_r_next;
	logic [54:0] sum_mag;
	logic [33:0] round_w;
	logic        over_w;
	logic [14:0] mag_w;

	assign accept   = item_valid && !item_stall;
	assign item_stall = state_q != ST_IDLE;
	assign mul_done = mul_b_q == '0;
	assign fire     = state_q == ST_FIN && (!result_valid_q || !result_stall);

	assign roll_mag = roll_angle[14] ? 15'(-roll_angle) : roll_angle;
	assign phase_w  = prod_q + PHASE_RND;
	assign idx_w    = phase_w[42-SINE_TABLE_BITS +: SINE_TABLE_BITS];
	assign quad_w   = phase_w[43:42];

	assign sin_w     = sin_neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});
	assign err_w     = 17'(target_q) - 17'(sin_w);
	assign err_w_mag = err_w[16] ? 17'(-err_w) : err_w;
	assign err_mag   = err_q[16] ? 17'(-err_q) : err_q;
	assign de_mag    = de_q[17] ? 18'(-de_q) : de_q;

	assign acc_w = 49'(integral_q) + (err_q[16] ? -$signed({12'd0, prod_q[36:0]})
		: $signed({12'd0, prod_q[36:0]}));
	always_comb begin
		priority if (acc_w > sepv_pkg::INTEGRAL_MAX)
			acc_sat = sepv_pkg::INTEGRAL_MAX;
		else if (acc_w < -sepv_pkg::INTEGRAL_MAX)
			acc_sat = -sepv_pkg::INTEGRAL_MAX;
		else
			acc_sat = acc_w;
	end
	assign acc_mag = acc_sat[48] ? 48'(-acc_sat) : acc_sat[47:0];

	assign div_t      = {div_r_q, div_n_q[63]};
	assign div_ge     = div_t >= {1'b0, div_d_q};
	assign div_r_next = div_ge ? 20'(div_t - {1'b0, div_d_q}) : div_t[19:0];

	assign sum_mag = sum_q[55] ? 55'(-sum_q) : sum_q[54:0];
	assign round_w = 34'((56'(sum_mag) + 56'd2097152) >> 22);
	assign over_w  = round_w > 34'(limit_q);
	assign mag_w   = over_w ? limit_q : round_w[14:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
			kp_q           <= '0;
			ki_q           <= '0;
			kd_q           <= '0;
			limit_q        <= sepv_pkg::LIMIT_RESET;
			target_q       <= '0;
			integral_q     <= '0;
			prev_q         <= '0;
		end else begin
			if (write_enable) begin
				unique case (reg_index)
					sepv_pkg::REG_KP:     kp_q <= write_data;
					sepv_pkg::REG_KI:     ki_q <= write_data;
					sepv_pkg::REG_KD:     kd_q <= write_data;
					sepv_pkg::REG_LIMIT:  limit_q <= write_data[14:0];
					sepv_pkg::REG_TARGET: target_q <= $signed(write_data);
					default: ;
				endcase
			end
			if (fire)
				result_valid_q <= 1'b1;
			else if (result_valid_q && !result_stall)
				result_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE:  if (accept) state_q <= ST_PHASE;
				ST_PHASE: if (mul_done) state_q <= ST_ROM;
				ST_ROM:   state_q <= ST_SINE;
				ST_SINE: begin
					prev_q  <= err_w;
					state_q <= ST_MP;
				end
				ST_MP:    if (mul_done) state_q <= ST_ME;
				ST_ME: begin
					if (mul_done) begin
						integral_q <= acc_sat[47:0];
						state_q    <= ST_MI;
					end
				end
				ST_MI: begin
					cnt_q <= '0;
					if (mul_done) state_q <= ST_DI;
				end
				ST_DI: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= ST_ADDI;
				end
				ST_ADDI:  state_q <= ST_MD1;
				ST_MD1:   if (mul_done) state_q <= ST_MD2;
				ST_MD2: begin
					cnt_q <= '0;
					if (mul_done) state_q <= ST_DD;
				end
				ST_DD: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= ST_ADDD;
				end
				ST_ADDD:  state_q <= ST_FIN;
				ST_FIN:   if (fire) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk)
		rom_q <= SINE_ROM[addr_q];

	always_ff @(posedge clk) begin
		if (mul_b_q != '0) begin
			if (mul_b_q[0])
				prod_q <= prod_q + mul_a_q;
			mul_a_q <= {mul_a_q[62:0], 1'b0};
			mul_b_q <= {1'b0, mul_b_q[19:1]};
		end
		if (state_q == ST_DI || state_q == ST_DD) begin
			div_r_q <= div_r_next;
			div_n_q <= {div_n_q[62:0], div_ge};
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					roll_neg_q <= roll_angle[14];
					dt_q       <= (elapsed_us == '0) ? 20'd1 : elapsed_us;
					mul_a_q    <= sepv_pkg::INV_TWO_PI_Q32;
					mul_b_q    <= 20'(roll_mag);
					prod_q     <= '0;
				end
			end
			ST_PHASE: begin
				if (mul_done) begin
					addr_q    <= quad_w[0] ? AW'(QUARTER) - AW'(idx_w) : AW'(idx_w);
					sin_neg_q <= quad_w[1] ^ roll_neg_q;
				end
			end
			ST_SINE: begin
				err_q   <= err_w;
				de_q    <= 18'(err_w) - 18'(prev_q);
				mul_a_q <= 64'(err_w_mag);
				mul_b_q <= 20'(kp_q);
				prod_q  <= '0;
			end
			ST_MP: begin
				if (mul_done) begin
					sum_q   <= err_q[16] ? -$signed(56'(prod_q[32:0]))
						: $signed(56'(prod_q[32:0]));
					mul_a_q <= 64'(err_mag);
					mul_b_q <= dt_q;
					prod_q  <= '0;
				end
			end
			ST_ME: begin
				if (mul_done) begin
					ineg_q  <= acc_sat[48];
					mul_a_q <= 64'(acc_mag);
					mul_b_q <= 20'(ki_q);
					prod_q  <= '0;
				end
			end
			ST_MI: begin
				div_n_q <= prod_q;
				div_d_q <= sepv_pkg::US_PER_SECOND;
				div_r_q <= '0;
			end
			ST_ADDI: begin
				sum_q   <= sum_q + (ineg_q ? -$signed(56'(div_n_q[54:0]))
					: $signed(56'(div_n_q[54:0])));
				mul_a_q <= 64'(de_mag);
				mul_b_q <= 20'(kd_q);
				prod_q  <= '0;
			end
			ST_MD1: begin
				if (mul_done) begin
					mul_a_q <= prod_q;
					mul_b_q <= sepv_pkg::US_PER_SECOND;
					prod_q  <= '0;
				end
			end
			ST_MD2: begin
				div_n_q <= prod_q;
				div_d_q <= dt_q;
				div_r_q <= '0;
			end
			ST_ADDD: begin
				sum_q <= sum_q + (de_q[17] ? -$signed(56'(div_n_q[54:0]))
					: $signed(56'(div_n_q[54:0])));
			end
			ST_FIN: begin
				if (fire) begin
					vel_q <= (sum_q > 0) ? -$signed({1'b0, mag_w}) : $signed({1'b0, mag_w});
					lim_q <= over_w;
				end
			end
			default: ;
		endcase
	end

	assign result_valid   = result_valid_q;
	assign wheel_velocity = vel_q;
	assign limited        = lim_q;

endmodule
`default_nettype wire

### sim/sepv_checker.sv
// Checker for the sine-error PID velocity controller: predicts each command and compares.
`timescale 1ns / 100ps
module sepv_checker #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              item_valid,
	input  wire                              item_stall,
	input  wire signed [14:0]                roll_angle,
	input  wire        [19:0]                elapsed_us,
	input  wire                              result_valid,
	input  wire                              result_stall,
	input  wire signed [15:0]                wheel_velocity,
	input  wire                              limited,
	input  wire                              write_enable,
	input  wire [sepv_pkg::REG_INDEX_W-1:0]  reg_index,
	input  wire [sepv_pkg::DATA_W-1:0]       write_data,
	output int                               errors,
	output int                               pending,
	output int                               commands_seen,
	output int                               clamped_seen
);

	localparam int QUARTER = 1 << SINE_TABLE_BITS;
	localparam longint ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;

	typedef struct packed {
		logic signed [15:0] velocity;
		logic               clamped;
	} command_t;

	command_t        command_queue[$];
	logic [15:0]     sine_lut[0:QUARTER];
	logic [15:0]     kp, ki, kd;
	logic [14:0]     vel_limit;
	logic signed [15:0] target;
	longint          err_integral;
	longint          prev_err;

	initial begin
		longint unsigned x, x2, t, s, e, one;
		longint unsigned divs[5];
		divs = '{110, 72, 42, 20, 6};
		one = 64'd1 << 30;
		for (int i = 0; i <= QUARTER; i++) begin
			x = (longint'(i) * sepv_pkg::HALF_PI_Q30 + (64'd1 << (SINE_TABLE_BITS - 1)))
				>> SINE_TABLE_BITS;
			x2 = (x * x) >> 30;
			t = one;
			for (int k = 0; k < 5; k++)
				t = one - ((x2 * t) >> 30) / divs[k];
			s = (x * t) >> 30;
			e = (s + (64'd1 << 15)) >> 16;
			if (e > 16384) e = 16384;
			sine_lut[i] = e[15:0];
		end
	end

	function automatic longint unsigned magnitude(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint sine_of(logic signed [14:0] ang);
		longint unsigned m, p;
		int unsigned q, idx;
		longint v;
		m = magnitude(longint'(ang));
		p = (m * sepv_pkg::INV_TWO_PI_Q32 * (64'd1 << (SINE_TABLE_BITS + 2)) + (64'd1 << 43))
			>> 44;
		q = 32'((p >> SINE_TABLE_BITS) & 64'd3);
		idx = 32'(p & 64'(QUARTER - 1));
		v = q[0] ? longint'(sine_lut[QUARTER - idx]) : longint'(sine_lut[idx]);
		if (q[1]) v = -v;
		if (ang < 0) v = -v;
		return v;
	endfunction

	function automatic command_t balance_step(logic signed [14:0] ang, logic [19:0] us);
		longint unsigned dt, r;
		longint err, acc, pterm, iterm, dterm, de, neg;
		command_t c;
		dt = (us == 0) ? 64'd1 : longint'(us);
		err = longint'(target) - sine_of(ang);
		pterm = longint'(longint'(kp) * magnitude(err));
		if (err < 0) pterm = -pterm;
		acc = err_integral + err * longint'(dt);
		if (acc > ACC_MAX) acc = ACC_MAX;
		if (acc < -ACC_MAX) acc = -ACC_MAX;
		err_integral = acc;
		iterm = longint'((longint'(ki) * magnitude(acc)) / 64'd1000000);
		if (acc < 0) iterm = -iterm;
		de = err - prev_err;
		dterm = longint'((longint'(kd) * magnitude(de) * 64'd1000000) / dt);
		if (de < 0) dterm = -dterm;
		prev_err = err;
		neg = -(pterm + iterm + dterm);
		r = (magnitude(neg) + (64'd1 << 21)) >> 22;
		c.clamped = 1'b0;
		if (r > vel_limit) begin
			r = vel_limit;
			c.clamped = 1'b1;
		end
		c.velocity = (neg < 0) ? -r[15:0] : r[15:0];
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		command_t want;
		if (!arst_n) begin
			kp = 0; ki = 0; kd = 0;
			vel_limit = sepv_pkg::LIMIT_RESET;
			target = 0;
			err_integral = 0;
			prev_err = 0;
			command_queue.delete();
			errors = 0; pending = 0; commands_seen = 0; clamped_seen = 0;
		end else begin
			if (write_enable) begin
				case (reg_index)
				sepv_pkg::REG_KP:     kp = write_data;
				sepv_pkg::REG_KI:     ki = write_data;
				sepv_pkg::REG_KD:     kd = write_data;
				sepv_pkg::REG_LIMIT:  vel_limit = write_data[14:0];
				sepv_pkg::REG_TARGET: target = write_data;
				default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				if (command_queue.size() == 0) begin
					$display("%0t: unexpected command vel=%0d limited=%0b", $time,
						wheel_velocity, limited);
					errors++;
				end else begin
					want = command_queue.pop_front();
					commands_seen++;
					if (want.clamped) clamped_seen++;
					if (wheel_velocity !== want.velocity) begin
						$display("%0t: wheel_velocity expected %0d got %0d", $time,
							want.velocity, wheel_velocity);
						errors++;
					end
					if (limited !== want.clamped) begin
						$display("%0t: limited expected %0b got %0b", $time,
							want.clamped, limited);
						errors++;
					end
				end
			end
			if (item_valid && !item_stall)
				command_queue.push_back(balance_step(roll_angle, elapsed_us));
			pending = command_queue.size();
		end
	end

endmodule

### sim/tb.sv
// Testbench top for the sine-error PID velocity controller: stimulus and verdict.
`timescale 1ns / 100ps
module tb;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 400;
	localparam int PHASES         = 8;
	localparam int PER_PHASE      = 235;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   item_valid = 1'b0;
	wire                    item_stall;
	logic signed [14:0]     roll_angle = '0;
	logic        [19:0]     elapsed_us = '0;
	wire                    result_valid;
	logic                   result_stall = 1'b0;
	wire signed [15:0]      wheel_velocity;
	wire                    limited;
	logic                   write_enable = 1'b0;
	logic [sepv_pkg::REG_INDEX_W-1:0] reg_index = '0;
	logic [sepv_pkg::DATA_W-1:0]      write_data = '0;

	int  errors, pending, commands_seen, clamped_seen;
	int  idle_cycles = 0;
	int  hold_left = 0;
	bit  busy_phase = 1'b0;

	always #4 clk = ~clk;

	sine_error_pid_velocity u_top (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.roll_angle(roll_angle), .elapsed_us(elapsed_us),
		.result_valid(result_valid), .result_stall(result_stall),
		.wheel_velocity(wheel_velocity), .limited(limited),
		.write_enable(write_enable), .reg_index(reg_index), .write_data(write_data)
	);

	sepv_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.roll_angle(roll_angle), .elapsed_us(elapsed_us),
		.result_valid(result_valid), .result_stall(result_stall),
		.wheel_velocity(wheel_velocity), .limited(limited),
		.write_enable(write_enable), .reg_index(reg_index), .write_data(write_data),
		.errors(errors), .pending(pending),
		.commands_seen(commands_seen), .clamped_seen(clamped_seen)
	);

	// receiver back-pressure: a fresh hold count per accepted command
	always @(posedge clk) begin
		int n;
		if (result_valid && !result_stall) begin
			n = busy_phase ? 0 : $urandom_range(0, 6);
			hold_left <= n;
			result_stall <= (n != 0);
		end else if (hold_left > 1) begin
			hold_left <= hold_left - 1;
		end else begin
			hold_left <= 0;
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || write_enable)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d commands outstanding", $time, pending);
			$display("[sine_error_pid_velocity] ERROR");
			$finish;
		end
	end

	task automatic send_request(logic signed [14:0] ang, logic [19:0] us);
		int gap;
		gap = busy_phase ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		roll_angle <= ang;
		elapsed_us <= us;
		do @(negedge clk); while (item_stall);
		@(posedge clk);
	endtask

	task automatic write_reg(logic [sepv_pkg::REG_INDEX_W-1:0] idx,
		logic [sepv_pkg::DATA_W-1:0] val);
		write_enable <= 1'b1;
		reg_index <= idx;
		write_data <= val;
		@(posedge clk);
		write_enable <= 1'b0;
	endtask

	task automatic drain;
		item_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_gain();
		return 16'($urandom_range(0, 65535) >> $urandom_range(0, 16));
	endfunction

	function automatic logic [19:0] rand_dt();
		case ($urandom_range(0, 9))
		0:       return 20'd0;
		1, 2:    return 20'($urandom);
		default: return 20'($urandom_range(1, 20000));
		endcase
	endfunction

	initial begin
		logic signed [14:0] ang;
		logic [15:0] tgt;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: zero gains, then a short directed sweep with live gains
		send_request(15'sd0, 20'd0);
		send_request(15'sd12868, 20'd1);
		drain();
		write_reg(sepv_pkg::REG_KP, 16'd512);
		write_reg(sepv_pkg::REG_KI, 16'd256);
		write_reg(sepv_pkg::REG_KD, 16'd64);
		write_reg(sepv_pkg::REG_LIMIT, 16'd1000);
		write_reg(sepv_pkg::REG_TARGET, 16'd4000);
		send_request(15'sd0, 20'd0);
		send_request(-15'sd12868, 20'd1);
		send_request(15'sd12868, 20'hFFFFF);
		send_request(15'sh4000, 20'd1000);
		send_request(15'sd16383, 20'd1000);
		send_request(15'sd6434, 20'd0);
		send_request(-15'sd6434, 20'd500000);
		send_request(15'sd3217, 20'd10);
		send_request(15'sd9651, 20'd999999);
		send_request(15'sd1, 20'd1);
		send_request(-15'sd1, 20'd2);
		send_request(15'sd12868, 20'h55555);
		send_request(-15'sd12868, 20'hAAAAA);
		drain();
		// integral saturation: full gains, long intervals, one-sided error
		write_reg(sepv_pkg::REG_KP, 16'hFFFF);
		write_reg(sepv_pkg::REG_KI, 16'hFFFF);
		write_reg(sepv_pkg::REG_KD, 16'hFFFF);
		write_reg(sepv_pkg::REG_LIMIT, 16'h7FFF);
		write_reg(sepv_pkg::REG_TARGET, 16'd16384);
		repeat (6) send_request(-15'sd6434, 20'hFFFFF);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			busy_phase = (ph == 3);
			case (ph)
			0: begin
				write_reg(sepv_pkg::REG_KP, 16'd0); write_reg(sepv_pkg::REG_KI, 16'd0);
				write_reg(sepv_pkg::REG_KD, 16'd0);
				write_reg(sepv_pkg::REG_LIMIT, 16'd0); tgt = -16'sd16384;
			end
			1: begin
				write_reg(sepv_pkg::REG_KP, 16'hFFFF); write_reg(sepv_pkg::REG_KI, 16'hFFFF);
				write_reg(sepv_pkg::REG_KD, 16'hFFFF);
				write_reg(sepv_pkg::REG_LIMIT, 16'h7FFF); tgt = 16'sd16384;
			end
			default: begin
				write_reg(sepv_pkg::REG_KP, rand_gain());
				write_reg(sepv_pkg::REG_KI, rand_gain());
				write_reg(sepv_pkg::REG_KD, rand_gain());
				write_reg(sepv_pkg::REG_LIMIT,
					16'($urandom_range(0, 65535) >> $urandom_range(0, 15)));
				tgt = 16'($signed($urandom_range(0, 32768)) - 16384);
			end
			endcase
			write_reg(sepv_pkg::REG_TARGET, tgt);
			for (int n = 0; n < PER_PHASE; n++) begin
				if ($urandom_range(0, 7) == 0)
					ang = 15'($urandom);
				else
					ang = 15'($signed($urandom_range(0, 25736)) - 12868);
				send_request(ang, rand_dt());
			end
			drain();
		end
		busy_phase = 1'b0;

		$display("%0d commands checked over %0d gain settings, %0d of them clamped",
			commands_seen, PHASES + 3, clamped_seen);
		if (errors == 0)
			$display("[sine_error_pid_velocity] OK");
		else
			$display("[sine_error_pid_velocity] ERROR");
		$finish;
	end

endmodule
